@@ rtl/core/sre_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sre_pkg
// Shared types and helpers for the color Sobel edge-magnitude filter.
// ----------------------------------------------------------------------------
package sre_pkg;

    // Number of entries in the job queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [10:0] width;
        logic [15:0] height;
        logic        restart;
    } t_cfg;

    // One result job: the eight neighbors of the target pixel after
    // border mirroring, plus the sideband flags of the result.
    typedef struct packed {
        logic [23:0] tl;
        logic [23:0] tc;
        logic [23:0] tr;
        logic [23:0] ml;
        logic [23:0] mr;
        logic [23:0] bl;
        logic [23:0] bc;
        logic [23:0] br;
        logic        run_last;
        logic        frame_last;
    } t_job;

    function automatic logic [7:0] chan_of(logic [23:0] p, logic [1:0] k);
        return p[8*k +: 8];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/sobel_rgb_edge_magnitude.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_rgb_edge_magnitude
// Color Sobel gradient magnitude over a raster pixel stream, mirror borders.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the valid/ready input channel, one item
// per pixel with three 8-bit channels. Each pixel causes zero to four result
// items on the valid/ready output channel; results lag the input by one row
// and one column, and the pixels of the last row also flush the bottom row.
// The front end loads each pixel into the window and then, when the pixel
// causes results, steps through four job slots (holding while the queue is
// full); it takes no new pixel until it is back in idle. The back end
// computes one result at a time with a bit-serial square root run once per
// color channel, and takes the next job only after its result is taken.
// A two-entry job queue sits between the two, so input keeps flowing while a
// finished result waits for a stalled receiver; when the queue fills, the
// input ready drops. Frame geometry is set through the APB registers
// frame_width (address 0) and frame_height (address 4); a write restarts the
// frame. Reset clears the counters and restores 640x480; line stores need no
// clearing since unwritten rows never reach a result.
// ----------------------------------------------------------------------------
module sobel_rgb_edge_magnitude import sre_pkg::*; #(
    parameter int MAX_WIDTH      = 1024,
    parameter int SQRT_FRAC_BITS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_pixel_ch0,
    input  wire logic [7:0]  i_pixel_ch1,
    input  wire logic [7:0]  i_pixel_ch2,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_edge_level,
    output logic             o_run_last,
    output logic             o_frame_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [10:0] r_frame_width;
    logic [15:0] r_frame_height;
    logic        r_restart;
    logic        wr_en;
    t_cfg        cfg;
    logic        q_push;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    t_job        push_job;
    t_job        pop_job;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = {21'b0, r_frame_width};
            REG_HEIGHT: prdata = {16'b0, r_frame_height};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd640;
            r_frame_height <= 16'd480;
            r_restart      <= 1'b0;
        end else begin
            r_restart <= wr_en;
            if (wr_en && paddr[2] == REG_WIDTH) begin
                r_frame_width <= pwdata[10:0];
            end
            if (wr_en && paddr[2] == REG_HEIGHT) begin
                r_frame_height <= pwdata[15:0];
            end
        end
    end

    assign cfg.width   = r_frame_width;
    assign cfg.height  = r_frame_height;
    assign cfg.restart = r_restart;

    sre_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pixel_ch0(i_pixel_ch0),
        .i_pixel_ch1(i_pixel_ch1),
        .i_pixel_ch2(i_pixel_ch2),
        .o_push     (q_push),
        .o_job      (push_job),
        .i_full     (q_full)
    );

    sre_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (push_job),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_job  (pop_job),
        .i_pop  (q_pop)
    );

    sre_back #(
        .SQRT_FRAC_BITS(SQRT_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_job       (pop_job),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_edge_level(o_edge_level),
        .o_run_last  (o_run_last),
        .o_frame_last(o_frame_last)
    );

endmodule
`default_nettype wire

@@ rtl/core/sre_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sre_queue
// Small job queue that lets the window front end and the arithmetic back
// end stall independently.
// ----------------------------------------------------------------------------
module sre_queue import sre_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_job,
    input  wire logic i_pop
);

    t_job                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QPTR_W:0]     r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("job popped from an empty queue");
    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill level did not follow a push");
`endif

endmodule
`default_nettype wire

@@ rtl/core/sre_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sre_front
// Accepts pixels, keeps the two line stores and the 3x3 window, tracks the
// raster position and issues one job per result the pixel causes.
// ----------------------------------------------------------------------------
module sre_front import sre_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_pixel_ch0,
    input  wire logic [7:0] i_pixel_ch1,
    input  wire logic [7:0] i_pixel_ch2,
    output logic            o_push,
    output t_job            o_job,
    input  wire logic       i_full
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_LOAD = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate     r_state;
    logic [23:0] mem_up [MAX_WIDTH];
    logic [23:0] mem_lo [MAX_WIDTH];
    logic [23:0] r_up_rd;
    logic [23:0] r_lo_rd;
    logic [23:0] r_pix;
    logic [23:0] r_win [9];
    logic [CW-1:0] r_col;
    logic [15:0] r_row;
    logic [3:0]  r_mask;
    logic [1:0]  r_idx;
    logic        r_top1;
    logic        r_left2;

    logic [WW-1:0] eff_w;
    logic [15:0]   eff_h;
    logic          accept;
    logic          col_last;
    logic          row_last;
    logic          first_ok;
    logic [2:0][23:0] row0, row1, row2, trow, mrow, brow;
    logic [1:0]    lsel, csel, rsel;
    logic          advance;
    logic          is_last;

    always_comb begin
        if ({21'b0, i_cfg.width} > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else if (i_cfg.width < 11'd2) begin
            eff_w = WW'(2);
        end else begin
            eff_w = WW'(i_cfg.width);
        end
        eff_h = (i_cfg.height < 16'd2) ? 16'd2 : i_cfg.height;
    end

    // No item is taken while the counters are being cleared after a write.
    assign o_ready  = (r_state == F_IDLE) && !i_cfg.restart;
    assign accept   = i_valid && o_ready;
    assign col_last = (WW'(r_col) == eff_w - 1'b1);
    assign row_last = (r_row == eff_h - 16'd1);
    assign first_ok = (r_row != 16'd0) && (r_col != '0);

    // Line stores: read on accept, written back once the old data is out.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up_rd <= mem_up[r_col];
            r_lo_rd <= mem_lo[r_col];
        end
        if (r_state == F_LOAD) begin
            mem_up[r_col] <= r_lo_rd;
            mem_lo[r_col] <= r_pix;
        end
    end

    // Job assembly with mirrored borders. Bit 1 of the job index selects
    // the bottom-row variant and bit 0 the right-column variant.
    always_comb begin
        row0 = {r_win[2], r_win[1], r_win[0]};
        row1 = {r_win[5], r_win[4], r_win[3]};
        row2 = {r_win[8], r_win[7], r_win[6]};
        if (r_idx[1]) begin
            trow = row1;
            mrow = row2;
            brow = row1;
        end else begin
            trow = r_top1 ? row2 : row0;
            mrow = row1;
            brow = row2;
        end
        if (r_idx[0]) begin
            lsel = 2'd1;
            csel = 2'd2;
            rsel = 2'd1;
        end else begin
            lsel = r_left2 ? 2'd2 : 2'd0;
            csel = 2'd1;
            rsel = 2'd2;
        end
        case (r_idx)
            2'd0:    is_last = (r_mask[3:1] == 3'b000);
            2'd1:    is_last = (r_mask[3:2] == 2'b00);
            2'd2:    is_last = !r_mask[3];
            default: is_last = 1'b1;
        endcase
        o_job.tl         = trow[lsel];
        o_job.tc         = trow[csel];
        o_job.tr         = trow[rsel];
        o_job.ml         = mrow[lsel];
        o_job.mr         = mrow[rsel];
        o_job.bl         = brow[lsel];
        o_job.bc         = brow[csel];
        o_job.br         = brow[rsel];
        o_job.run_last   = is_last;
        o_job.frame_last = (r_idx == 2'd3);
    end

    assign o_push  = (r_state == F_PUSH) && r_mask[r_idx] && !i_full;
    assign advance = !r_mask[r_idx] || !i_full;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= {i_pixel_ch2, i_pixel_ch1, i_pixel_ch0};
        end
        if (r_state == F_LOAD) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= r_up_rd;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= r_lo_rd;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= r_pix;
            r_mask   <= {first_ok && col_last && row_last, first_ok && row_last,
                         first_ok && col_last, first_ok};
            r_top1   <= (r_row == 16'd1);
            r_left2  <= (r_col == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_idx   <= '0;
        end else if (i_cfg.restart) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_state <= F_LOAD;
                    end
                end
                F_LOAD: begin
                    r_idx <= '0;
                    if (col_last) begin
                        r_col <= '0;
                        r_row <= row_last ? 16'd0 : r_row + 16'd1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    r_state <= first_ok ? F_PUSH : F_IDLE;
                end
                F_PUSH: begin
                    if (advance) begin
                        if (r_idx == 2'd3) begin
                            r_state <= F_IDLE;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/sre_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sre_back
// Computes one edge level per job: Sobel sums per channel, a bit-serial
// square root per channel, then the rounded average of the three.
// ----------------------------------------------------------------------------
module sre_back import sre_pkg::*; #(
    parameter int SQRT_FRAC_BITS = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output logic [7:0] o_edge_level,
    output logic      o_run_last,
    output logic      o_frame_last
);

    localparam int RTW   = 9 + SQRT_FRAC_BITS;
    localparam int RW    = RTW + 2;
    localparam int SW    = 18 + 2 * SQRT_FRAC_BITS;
    localparam int STEPS = SW / 2;
    localparam int NW    = $clog2(STEPS);
    localparam int TW    = RTW + 2;

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_GRAD = 7'b0000010,
        B_SQR  = 7'b0000100,
        B_ROOT = 7'b0001000,
        B_DIV  = 7'b0010000,
        B_MUL  = 7'b0100000,
        B_OUT  = 7'b1000000
    } t_bstate;

    t_bstate       r_state;
    t_job          r_job;
    logic [1:0]    r_k;
    logic [7:0]    r_ax;
    logic [7:0]    r_ay;
    logic [SW-1:0] r_rad;
    logic [RW-1:0] r_rem;
    logic [RTW-1:0] r_root;
    logic [NW-1:0] r_cnt;
    logic [TW-1:0] r_total;
    logic [11:0]   r_q;
    logic [7:0]    r_level;
    logic          r_run;
    logic          r_frame;

    logic [9:0]    gx_pos, gx_neg, gy_pos, gy_neg;
    logic [15:0]   sq_x, sq_y;
    logic [16:0]   sum_sq;
    logic [RW-1:0] rem_sh, trial;
    logic [RW-1:0] rem_n;
    logic [RTW-1:0] root_n;
    logic [TW:0]   rounded;
    logic [24:0]   prod;

    function automatic logic [7:0] mag_clamp(logic [9:0] a, logic [9:0] b);
        logic [9:0] d;
        d = (a >= b) ? a - b : b - a;
        return (d > 10'd255) ? 8'd255 : d[7:0];
    endfunction

    always_comb begin
        gx_pos = {2'b0, chan_of(r_job.tr, r_k)} + {1'b0, chan_of(r_job.mr, r_k), 1'b0}
               + {2'b0, chan_of(r_job.br, r_k)};
        gx_neg = {2'b0, chan_of(r_job.tl, r_k)} + {1'b0, chan_of(r_job.ml, r_k), 1'b0}
               + {2'b0, chan_of(r_job.bl, r_k)};
        gy_pos = {2'b0, chan_of(r_job.bl, r_k)} + {1'b0, chan_of(r_job.bc, r_k), 1'b0}
               + {2'b0, chan_of(r_job.br, r_k)};
        gy_neg = {2'b0, chan_of(r_job.tl, r_k)} + {1'b0, chan_of(r_job.tc, r_k), 1'b0}
               + {2'b0, chan_of(r_job.tr, r_k)};
        sq_x   = r_ax * r_ax;
        sq_y   = r_ay * r_ay;
        sum_sq = {1'b0, sq_x} + {1'b0, sq_y};
        // One result bit per step of the digit-by-digit square root.
        rem_sh = {r_rem[RW-3:0], r_rad[SW-1:SW-2]};
        trial  = {r_root, 2'b01};
        if (rem_sh >= trial) begin
            rem_n  = rem_sh - trial;
            root_n = {r_root[RTW-2:0], 1'b1};
        end else begin
            rem_n  = rem_sh;
            root_n = {r_root[RTW-2:0], 1'b0};
        end
        rounded = {1'b0, r_total} + (TW+1)'(3 << (SQRT_FRAC_BITS - 1));
        // Division by three as a multiply by a scaled reciprocal.
        prod    = {13'b0, r_q} * 25'd2731;
    end

    assign o_pop        = (r_state == B_IDLE) && i_valid;
    assign o_valid      = (r_state == B_OUT);
    assign o_edge_level = r_level;
    assign o_run_last   = r_run;
    assign o_frame_last = r_frame;

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job   <= i_job;
                r_total <= '0;
            end
            B_GRAD: begin
                r_ax <= mag_clamp(gx_pos, gx_neg);
                r_ay <= mag_clamp(gy_pos, gy_neg);
            end
            B_SQR: begin
                r_rad  <= {1'b0, sum_sq, {(2*SQRT_FRAC_BITS){1'b0}}};
                r_rem  <= '0;
                r_root <= '0;
            end
            B_ROOT: begin
                r_rad  <= {r_rad[SW-3:0], 2'b00};
                r_rem  <= rem_n;
                r_root <= root_n;
                if (r_cnt == NW'(STEPS - 1)) begin
                    r_total <= r_total + TW'(root_n);
                end
            end
            B_DIV: begin
                r_q <= 12'(rounded >> SQRT_FRAC_BITS);
            end
            B_MUL: begin
                r_level <= (prod[24:13] > 12'd255) ? 8'd255 : prod[20:13];
                r_run   <= r_job.run_last;
                r_frame <= r_job.frame_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_k     <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        r_k     <= '0;
                        r_state <= B_GRAD;
                    end
                end
                B_GRAD: r_state <= B_SQR;
                B_SQR: begin
                    r_cnt   <= '0;
                    r_state <= B_ROOT;
                end
                B_ROOT: begin
                    if (r_cnt == NW'(STEPS - 1)) begin
                        if (r_k == 2'd2) begin
                            r_state <= B_DIV;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= B_GRAD;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                B_DIV: r_state <= B_MUL;
                B_MUL: r_state <= B_OUT;
                B_OUT: begin
                    if (i_ready) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
